FILE: design/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher engine.
// No dependencies; imported by rc4_ctrl, rc4_stream_cipher and rc4_checker.
`default_nettype none

package rc4_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int MAX_KEY_BYTES = 256;
    localparam int BYTE_W        = 8;
    localparam int ADDR_W        = $clog2(TABLE_SIZE);
    localparam int COUNT_W       = ADDR_W + 1;

    typedef enum logic [1:0] {
        ACT_KEY   = 2'd0,
        ACT_FINAL = 2'd1,
        ACT_DATA  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_KEY_STORED = 2'd1,
        ST_NOT_KEYED  = 2'd2,
        ST_KEY_REJECT = 2'd3
    } t_status;

    // one write port and one registered read port of a byte-wide memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

FILE: design/rc4_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/rc4_ctrl.sv
// RC4 sequencer: key collection, key schedule and keystream generation.
// Drives the permutation and key memories; uses rc4_pkg.
`default_nettype none

module rc4_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rc4_pkg::t_action                i_action,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      i_byte_value,
    output rc4_pkg::t_result                     o_res,
    input  wire logic                            i_res_ready,
    output rc4_pkg::t_ram_req                    o_perm_req,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      i_perm_rdata,
    output rc4_pkg::t_ram_req                    o_key_req,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      i_key_rdata
);

    import rc4_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_INIT    = 10'b00_0000_0010,
        S_KS_RD_I = 10'b00_0000_0100,
        S_KS_RD_J = 10'b00_0000_1000,
        S_KS_WR_I = 10'b00_0001_0000,
        S_KS_WR_J = 10'b00_0010_0000,
        S_KS_FIN  = 10'b00_0100_0000,
        S_D_RD_J  = 10'b00_1000_0000,
        S_D_WR_I  = 10'b01_0000_0000,
        S_D_WR_J  = 10'b10_0000_0000
    } t_state;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_KEY_BYTES);
    localparam logic [ADDR_W-1:0]  LAST_IDX  = ADDR_W'(TABLE_SIZE - 1);

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_keyed, n_keyed;
    logic [ADDR_W-1:0]   r_i, n_i;
    logic [ADDR_W-1:0]   r_j, n_j;
    logic [ADDR_W-1:0]   r_k, n_k;
    logic [ADDR_W-1:0]   r_kidx, n_kidx;
    logic [COUNT_W-1:0]  r_n, n_n;
    logic [BYTE_W-1:0]   r_x, n_x;
    logic [BYTE_W-1:0]   r_y, n_y;
    logic [ADDR_W-1:0]   r_a, n_a;
    logic [BYTE_W-1:0]   r_b, n_b;

    logic                accept;
    logic                has_room;
    logic                reject;
    logic [ADDR_W-1:0]   sched_j;
    logic [BYTE_W-1:0]   ks_byte;

    assign accept   = i_in_valid && o_in_ready;
    assign has_room = (r_count < MAX_COUNT);
    // the final byte is dropped too when the store is already full
    assign reject   = r_ovf || !has_room;
    assign sched_j  = r_j + i_perm_rdata + i_key_rdata;

    // keystream byte after the swap: S[i] now holds y and S[j] holds x
    always_comb begin
        if (r_a == r_j) begin
            ks_byte = r_x;
        end else if (r_a == r_i) begin
            ks_byte = r_y;
        end else begin
            ks_byte = i_perm_rdata;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && i_res_ready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_keyed = r_keyed;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_kidx  = r_kidx;
        n_n     = r_n;
        n_x     = r_x;
        n_y     = r_y;
        n_a     = r_a;
        n_b     = r_b;

        o_res        = '0;
        o_res.status = ST_DONE;

        o_perm_req         = '0;
        o_perm_req.rd_addr = r_k;

        o_key_req         = '0;
        o_key_req.wr_addr = r_count[ADDR_W-1:0];
        o_key_req.wr_data = i_byte_value;
        o_key_req.rd_addr = r_kidx;

        unique case (r_state)
            S_IDLE: begin
                o_perm_req.rd_addr = r_i + 1'b1;
                if (accept) begin
                    unique case (i_action)
                        ACT_KEY: begin
                            if (has_room) begin
                                o_key_req.wr_en = 1'b1;
                                n_count         = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            o_res.valid  = 1'b1;
                            o_res.status = ST_KEY_STORED;
                        end
                        ACT_FINAL: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                            n_keyed = 1'b0;
                            n_i     = '0;
                            n_j     = '0;
                            if (reject) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_KEY_REJECT;
                            end else begin
                                o_key_req.wr_en = 1'b1;
                                n_n             = r_count + 1'b1;
                                n_k             = '0;
                                n_kidx          = '0;
                                n_state         = S_INIT;
                            end
                        end
                        ACT_DATA: begin
                            if (r_keyed) begin
                                n_i     = r_i + 1'b1;
                                n_b     = i_byte_value;
                                n_state = S_D_RD_J;
                            end else begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_NOT_KEYED;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count     = '0;
                            n_ovf       = 1'b0;
                            n_keyed     = 1'b0;
                            n_i         = '0;
                            n_j         = '0;
                            o_res.valid = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // identity fill of the permutation
            S_INIT: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_k;
                o_perm_req.wr_data = r_k;
                n_k                = r_k + 1'b1;
                if (r_k == LAST_IDX) begin
                    n_state = S_KS_RD_I;
                end
            end
            S_KS_RD_I: begin
                o_perm_req.rd_addr = r_k;
                n_state            = S_KS_RD_J;
            end
            S_KS_RD_J: begin
                o_perm_req.rd_addr = sched_j;
                n_j                = sched_j;
                n_x                = i_perm_rdata;
                n_state            = S_KS_WR_I;
            end
            S_KS_WR_I: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_k;
                o_perm_req.wr_data = i_perm_rdata;
                n_state            = S_KS_WR_J;
            end
            S_KS_WR_J: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_j;
                o_perm_req.wr_data = r_x;
                n_k                = r_k + 1'b1;
                // key index runs k mod key length
                if ((COUNT_W'(r_kidx) + 1'b1) == r_n) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + 1'b1;
                end
                if (r_k == LAST_IDX) begin
                    n_state = S_KS_FIN;
                end else begin
                    n_state = S_KS_RD_I;
                end
            end
            S_KS_FIN: begin
                if (i_res_ready) begin
                    o_res.valid = 1'b1;
                    n_i         = '0;
                    n_j         = '0;
                    n_keyed     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_D_RD_J: begin
                o_perm_req.rd_addr = r_j + i_perm_rdata;
                n_j                = r_j + i_perm_rdata;
                n_x                = i_perm_rdata;
                n_state            = S_D_WR_I;
            end
            S_D_WR_I: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_i;
                o_perm_req.wr_data = i_perm_rdata;
                o_perm_req.rd_addr = r_x + i_perm_rdata;
                n_y                = i_perm_rdata;
                n_a                = r_x + i_perm_rdata;
                n_state            = S_D_WR_J;
            end
            // repeats its write while the result waits; forwarding covers it
            S_D_WR_J: begin
                o_perm_req.wr_en   = 1'b1;
                o_perm_req.wr_addr = r_j;
                o_perm_req.wr_data = r_x;
                o_perm_req.rd_addr = r_a;
                if (i_res_ready) begin
                    o_res.valid = 1'b1;
                    o_res.data  = r_b ^ ks_byte;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_keyed <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_kidx  <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_keyed <= n_keyed;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_kidx  <= n_kidx;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_a <= n_a;
        r_b <= n_b;
    end

endmodule

`default_nettype wire

FILE: design/rc4_stream_cipher.sv
// RC4 engine: key byte, clear, refused data and rejected final byte give their result in the
// cycle after acceptance. A data byte passes S_D_RD_J, S_D_WR_I and S_D_WR_J before the next
// is accepted (three dependent permutation reads, two writes through the single-port-pair RAM).
// The final key byte runs the key schedule: identity fill of 256 entries, then one swap each.
// Synchronous active-low reset leaves the engine unkeyed; memory contents are not cleared.
// Top level: output register plus the sequencer and its two RAMs; uses rc4_pkg, rc4_ctrl, rc4_ram.
`default_nettype none

module rc4_stream_cipher (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rc4_pkg::t_action                i_action,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      i_byte_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]           o_data_out,
    output rc4_pkg::t_status                     o_status
);

    import rc4_pkg::*;

    t_result           res;
    t_ram_req          perm_req;
    t_ram_req          key_req;
    logic [BYTE_W-1:0] perm_rdata;
    logic [BYTE_W-1:0] key_rdata;
    logic              res_ready;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_data;
    t_status           r_status;

    assign res_ready = !r_out_valid || i_out_ready;

    rc4_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_perm_req   (perm_req),
        .i_perm_rdata (perm_rdata),
        .o_key_req    (key_req),
        .i_key_rdata  (key_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm_ram (
        .i_clk     (i_clk),
        .i_wr_en   (perm_req.wr_en),
        .i_wr_addr (perm_req.wr_addr),
        .i_wr_data (perm_req.wr_data),
        .i_rd_addr (perm_req.rd_addr),
        .o_rd_data (perm_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_req.wr_en),
        .i_wr_addr (key_req.wr_addr),
        .i_wr_data (key_req.wr_data),
        .i_rd_addr (key_req.rd_addr),
        .o_rd_data (key_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_data   <= res.data;
            r_status <= res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data;
    assign o_status    = r_status;

endmodule

`default_nettype wire

FILE: design/rc4_checker.sv
// Port-level assertions for rc4_stream_cipher, bound to the top level.
// Uses rc4_pkg for action and status codes.
`default_nettype none

module rc4_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_ready,
    input  wire rc4_pkg::t_action                i_action,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]      o_data_out,
    input  wire rc4_pkg::t_status                o_status
);

    import rc4_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_data_out) && $stable(o_status))
        else $error("stalled result changed");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DONE) |-> (o_data_out == '0))
        else $error("nonzero data with non-done status");

    a_key_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_KEY)
        |=> o_out_valid && (o_status == ST_KEY_STORED))
        else $error("key byte transaction without key-stored result");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

`default_nettype wire
